// ===== hdl/shct_pkg.sv =====
package shct_pkg;

  localparam int unsigned DefTableSize  = 65536;
  localparam int unsigned DefProbeLimit = 32;

  localparam logic [31:0] MixX     = 32'd2654435761;
  localparam logic [31:0] MixY     = 32'd805459861;
  localparam logic [31:0] MixLevel = 32'd1234567891;
  localparam logic [63:0] FinA     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FinB     = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FinShift = 33;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_MARK   = 2'd2,
    MODE_ERASE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NEW      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ERASED   = 3'd4,
    ST_MARKED   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_ERASE_RD,
    S_SHIFT_RD,
    S_SHIFT_HASH,
    S_SHIFT_NEXT,
    S_ERASE_FIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [7:0]  level;
    logic [31:0] y;
    logic [31:0] x;
  } key_t;

  typedef struct packed {
    logic        occ;
    logic [31:0] stamp;
    key_t        key;
  } entry_t;

endpackage

// ===== hdl/shct_hash.sv =====
module shct_hash #(
  parameter int unsigned IDX_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  shct_pkg::key_t     key_i,
  output logic               done_o,
  output logic [IDX_W-1:0]   slot_o
);
  import shct_pkg::*;

  logic             busy_q;
  logic [3:0]       step_q;
  key_t             key_q;
  logic [63:0]      h_q;
  logic [63:0]      t_q;
  logic [IDX_W-1:0] slot_q;
  logic             done_q;
  logic [31:0]      mult_a;
  logic [31:0]      mult_b;
  logic [63:0]      prod;
  logic [63:0]      fin_k;
  logic [63:0]      mix;

  // One 32x32 multiplier is shared by the key-mixing and finaliser steps; each
  // 64-bit finaliser product is built from three partial products in turn.
  assign fin_k = (step_q < 4'd7) ? FinA : FinB;
  assign prod  = {32'b0, mult_a} * {32'b0, mult_b};
  assign mix   = t_q ^ (t_q >> FinShift);

  always_comb begin
    mult_a = '0;
    mult_b = '0;
    case (step_q)
      4'd0: begin
        mult_a = key_q.x;
        mult_b = MixX;
      end
      4'd1: begin
        mult_a = key_q.y;
        mult_b = MixY;
      end
      4'd2: begin
        mult_a = {24'b0, key_q.level};
        mult_b = MixLevel;
      end
      4'd4, 4'd8: begin
        mult_a = h_q[31:0];
        mult_b = fin_k[31:0];
      end
      4'd5, 4'd9: begin
        mult_a = h_q[63:32];
        mult_b = fin_k[31:0];
      end
      4'd6, 4'd10: begin
        mult_a = h_q[31:0];
        mult_b = fin_k[63:32];
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
      key_q  <= '0;
      h_q    <= '0;
      t_q    <= '0;
      slot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        key_q  <= key_i;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        case (step_q)
          4'd0:                      h_q <= prod;
          4'd1, 4'd2:                h_q <= h_q ^ prod;
          4'd3:                      h_q <= h_q ^ (h_q >> FinShift);
          4'd4, 4'd8:                t_q <= prod;
          4'd5, 4'd6, 4'd9, 4'd10:   t_q[63:32] <= t_q[63:32] + prod[31:0];
          4'd7:                      h_q <= mix;
          4'd11: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            slot_q <= mix[IDX_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

// ===== hdl/spatial_hash_cell_table_top.sv =====
// Open-addressed cell table with linear probing and backward-shift erase.
// After reset the block sweeps the whole table once to clear it, with the
// input held off. Lookup, insert and mark are accepted, hashed in twelve
// steps around one shared 32x32 multiplier, probed at one slot per cycle
// (one read of the table memory per cycle, up to PROBE_LIMIT slots) and then
// handed over as a result. Erase of an empty slot goes straight to the
// hand-over. Erase of an occupied slot rehashes every entry of the cluster
// behind the erased slot to decide whether it shifts back. The hand-over
// waits while the output register still holds an earlier result. One item
// is processed at a time; the next one is taken while the previous result
// still waits at the output.
module spatial_hash_cell_table_top #(
  parameter int unsigned TABLE_SIZE  = shct_pkg::DefTableSize,
  parameter int unsigned PROBE_LIMIT = shct_pkg::DefProbeLimit
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cell_x[31:0], cell_y[63:32], level[71:64], frame_stamp[103:72],
  // slot_index[119:104]
  input  logic [119:0] s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // slot[15:0], stamp_out[47:16], entry_count[64:48], fail_count[96:65]
  output logic [103:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]   m_axis_tuser_o
);
  import shct_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_SIZE);
  localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);

  entry_t table_mem [TABLE_SIZE];
  entry_t rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;

  state_e        state_q, state_d;
  mode_e         mode_q, mode_d;
  key_t          key_q, key_d;
  logic [31:0]   ts_q, ts_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [IW-1:0] hole_q, hole_d;
  logic [IW:0]   n_q, n_d;
  logic [PW-1:0] probe_q, probe_d;
  entry_t        data_q, data_d;
  logic [IW:0]   cnt_q, cnt_d;
  logic [31:0]   fail_q, fail_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  status_e       res_status_q, res_status_d;
  logic [31:0]   res_stamp_q, res_stamp_d;
  logic          m_valid_q, m_valid_d;
  logic [15:0]   out_slot_q, out_slot_d;
  status_e       out_status_q, out_status_d;
  logic [31:0]   out_stamp_q, out_stamp_d;
  logic [16:0]   out_cnt_q, out_cnt_d;
  logic [31:0]   out_fail_q, out_fail_d;

  logic          hash_start;
  key_t          hash_key;
  logic          hash_done;
  logic [IW-1:0] hash_slot;

  key_t          in_key;
  logic [IW+15:0] idx_ext;
  logic [IW+15:0] slot_ext;
  logic [IW+17:0] cnt_ext;
  logic          key_match;
  logic          stays;

  shct_hash #(.IDX_W(IW)) u_shct_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= table_mem[mem_raddr];
  end

  assign in_key.x     = s_axis_tdata_i[31:0];
  assign in_key.y     = s_axis_tdata_i[63:32];
  assign in_key.level = s_axis_tdata_i[71:64];
  assign idx_ext      = {{IW{1'b0}}, s_axis_tdata_i[119:104]};
  assign slot_ext     = {16'b0, res_slot_q};
  assign cnt_ext      = {17'b0, cnt_q};
  assign key_match    = (rd_q.key == key_q);

  // An entry of the cluster keeps its place (is not shifted back) if its home
  // lies in the cyclic range (hole, j].
  always_comb begin
    if (hole_q <= addr_q) begin
      stays = (hole_q < hash_slot) && (hash_slot <= addr_q);
    end else begin
      stays = (hole_q < hash_slot) || (hash_slot <= addr_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    key_d        = key_q;
    ts_d         = ts_q;
    addr_d       = addr_q;
    hole_d       = hole_q;
    n_d          = n_q;
    probe_d      = probe_q;
    data_d       = data_q;
    cnt_d        = cnt_q;
    fail_d       = fail_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    res_stamp_d  = res_stamp_q;
    m_valid_d    = m_valid_q;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    out_stamp_d  = out_stamp_q;
    out_cnt_d    = out_cnt_q;
    out_fail_d   = out_fail_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = '0;
    mem_raddr    = addr_q;
    hash_start   = 1'b0;
    hash_key     = key_q;
    s_axis_tready_o = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          mode_d      = mode_e'(s_axis_tuser_i);
          key_d       = in_key;
          ts_d        = s_axis_tdata_i[103:72];
          res_stamp_d = '0;
          res_slot_d  = '0;
          if (mode_e'(s_axis_tuser_i) == MODE_ERASE) begin
            addr_d    = idx_ext[IW-1:0];
            mem_raddr = idx_ext[IW-1:0];
            state_d   = S_ERASE_RD;
          end else begin
            hash_start = 1'b1;
            hash_key   = in_key;
            state_d    = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          addr_d    = hash_slot;
          mem_raddr = hash_slot;
          probe_d   = '0;
          state_d   = S_PROBE;
        end
      end

      S_PROBE: begin
        if (rd_q.occ && key_match) begin
          res_slot_d   = addr_q;
          res_status_d = ST_FOUND;
          state_d      = S_RESP;
          case (mode_q)
            MODE_LOOKUP: res_stamp_d = rd_q.stamp;
            MODE_MARK: begin
              res_stamp_d = rd_q.stamp;
              if (ts_q != '0 && rd_q.stamp == ts_q) begin
                res_status_d = ST_MARKED;
              end else begin
                mem_we          = 1'b1;
                mem_wdata       = rd_q;
                mem_wdata.stamp = ts_q;
              end
            end
            default: res_stamp_d = '0;
          endcase
        end else if (!rd_q.occ) begin
          state_d = S_RESP;
          if (mode_q == MODE_LOOKUP) begin
            res_status_d = ST_NOTFOUND;
          end else begin
            mem_we          = 1'b1;
            mem_wdata.occ   = 1'b1;
            mem_wdata.key   = key_q;
            mem_wdata.stamp = (mode_q == MODE_MARK) ? ts_q : 32'd0;
            cnt_d           = cnt_q + 1'b1;
            res_slot_d      = addr_q;
            res_status_d    = ST_NEW;
          end
        end else if (probe_q == PW'(PROBE_LIMIT - 1)) begin
          state_d = S_RESP;
          if (mode_q == MODE_LOOKUP) begin
            res_status_d = ST_NOTFOUND;
          end else begin
            res_status_d = ST_FULL;
            if (fail_q != '1) begin
              fail_d = fail_q + 32'd1;
            end
          end
        end else begin
          probe_d   = probe_q + 1'b1;
          addr_d    = addr_q + 1'b1;
          mem_raddr = addr_q + 1'b1;
        end
      end

      S_ERASE_RD: begin
        res_slot_d = addr_q;
        if (!rd_q.occ) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          mem_we    = 1'b1;
          hole_d    = addr_q;
          n_d       = '0;
          addr_d    = addr_q + 1'b1;
          mem_raddr = addr_q + 1'b1;
          state_d   = S_SHIFT_RD;
        end
      end

      S_SHIFT_RD: begin
        // The slot at the current hole may still hold a stale copy of an
        // entry that has already moved back, so it counts as empty.
        if (!rd_q.occ || addr_q == hole_q) begin
          state_d = S_ERASE_FIN;
        end else begin
          data_d     = rd_q;
          hash_start = 1'b1;
          hash_key   = rd_q.key;
          state_d    = S_SHIFT_HASH;
        end
      end

      S_SHIFT_HASH: begin
        if (hash_done) begin
          if (!stays) begin
            mem_we    = 1'b1;
            mem_waddr = hole_q;
            mem_wdata = data_q;
            hole_d    = addr_q;
          end
          n_d     = n_q + 1'b1;
          addr_d  = addr_q + 1'b1;
          state_d = S_SHIFT_NEXT;
        end
      end

      S_SHIFT_NEXT: begin
        if (n_q == (IW+1)'(TABLE_SIZE)) begin
          state_d = S_ERASE_FIN;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end

      S_ERASE_FIN: begin
        mem_we       = 1'b1;
        mem_waddr    = hole_q;
        res_status_d = ST_ERASED;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d    = 1'b1;
          out_slot_d   = slot_ext[15:0];
          out_status_d = res_status_q;
          out_stamp_d  = res_stamp_q;
          out_cnt_d    = cnt_ext[16:0];
          out_fail_d   = fail_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      mode_q       <= MODE_LOOKUP;
      key_q        <= '0;
      ts_q         <= '0;
      addr_q       <= '0;
      hole_q       <= '0;
      n_q          <= '0;
      probe_q      <= '0;
      data_q       <= '0;
      cnt_q        <= '0;
      fail_q       <= '0;
      res_slot_q   <= '0;
      res_status_q <= ST_FOUND;
      res_stamp_q  <= '0;
      m_valid_q    <= 1'b0;
      out_slot_q   <= '0;
      out_status_q <= ST_FOUND;
      out_stamp_q  <= '0;
      out_cnt_q    <= '0;
      out_fail_q   <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      key_q        <= key_d;
      ts_q         <= ts_d;
      addr_q       <= addr_d;
      hole_q       <= hole_d;
      n_q          <= n_d;
      probe_q      <= probe_d;
      data_q       <= data_d;
      cnt_q        <= cnt_d;
      fail_q       <= fail_d;
      res_slot_q   <= res_slot_d;
      res_status_q <= res_status_d;
      res_stamp_q  <= res_stamp_d;
      m_valid_q    <= m_valid_d;
      out_slot_q   <= out_slot_d;
      out_status_q <= out_status_d;
      out_stamp_q  <= out_stamp_d;
      out_cnt_q    <= out_cnt_d;
      out_fail_q   <= out_fail_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_fail_q, out_cnt_q, out_stamp_q, out_slot_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ===== hdl/shct_checker.sv =====
module shct_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [103:0] m_axis_tdata_o,
  input logic [2:0]   m_axis_tuser_o
);
  import shct_pkg::*;

  // A result that is held back must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while busy");

  // A failed claim reports neither slot nor stamp.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_FULL |-> m_axis_tdata_o[47:0] == '0)
    else $error("table full result carries slot or stamp");

  // Claimed, erased and missed slots report a zero stamp.
  a_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_NEW || m_axis_tuser_o == ST_ERASED ||
                        m_axis_tuser_o == ST_NOTFOUND)
      |-> m_axis_tdata_o[47:16] == '0)
    else $error("stamp reported where none is held");

endmodule

bind spatial_hash_cell_table_top shct_checker u_shct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
